>>> rtl/core/pvfs_pkg.sv
// Shared constants for the pump and valve fill sequencer.
package pvfs_pkg;

  // Field widths
  localparam int unsigned PulsesW = 4;
  localparam int unsigned LevelW  = 12;
  localparam int unsigned MinPulW = 10;
  localparam int unsigned WindowW = 16;
  localparam int unsigned DurW    = 20;
  localparam int unsigned PhaseW  = 2;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] CfgLevelThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinPulses      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFlowWindow     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPumpRun        = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgValveOpen      = 3'd4;

  // Register reset values
  localparam logic [LevelW-1:0]  RstLevelThreshold = 12'd1800;
  localparam logic [MinPulW-1:0] RstMinPulses      = 10'd3;
  localparam logic [WindowW-1:0] RstFlowWindow     = 16'd1000;
  localparam logic [DurW-1:0]    RstPumpRun        = 20'd25000;
  localparam logic [DurW-1:0]    RstValveOpen      = 20'd30000;

  // Sequencer phase codes as seen on the result item
  localparam logic [PhaseW-1:0] PhIdle = 2'd0;
  localparam logic [PhaseW-1:0] PhPump = 2'd1;
  localparam logic [PhaseW-1:0] PhWait = 2'd2;
  localparam logic [PhaseW-1:0] PhOpen = 2'd3;

  localparam logic [MinPulW-1:0] PulseMax = '1;

endpackage

>>> rtl/core/pump_valve_fill_sequencer.sv
// Pump and valve fill sequencer: pulse window, phase timer and drive outputs.
// Path: a tick item accepted into the input register passes into the result register
//   once that register is free or being taken (input register, then result register).
// Throughput: one item per cycle while the sink takes results; the result register
//   frees as it is taken and the input stage refills in the same cycle, so no bubbles.
// Reset (rst_ni low, asynchronous): sequencer idle, pump off, valve open,
//   window and phase timers cleared, registers back to their defaults.
module pump_valve_fill_sequencer
  import pvfs_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Tick items: [3:0] tick_pulses, [15:4] level_sample
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Results: [0] pump_on, [1] valve_closed, [3:2] phase, [4] flow_detected,
  //          [5] level_reached, [7:6] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // Register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Compare width wide enough for both the phase timer and a 20-bit duration
  localparam int unsigned CmpW = (TIMER_BITS > DurW) ? TIMER_BITS : DurW;

  typedef enum logic [PhaseW-1:0] {
    ST_IDLE = PhIdle,
    ST_PUMP = PhPump,
    ST_WAIT = PhWait,
    ST_OPEN = PhOpen
  } phase_e;

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, a write to an unused index is dropped
  // ---------------------------------------------------------------------------
  logic [LevelW-1:0]  level_thr_q;
  logic [MinPulW-1:0] min_pulses_q;
  logic [WindowW-1:0] window_len_q;
  logic [DurW-1:0]    pump_run_q;
  logic [DurW-1:0]    open_time_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_thr_q  <= RstLevelThreshold;
      min_pulses_q <= RstMinPulses;
      window_len_q <= RstFlowWindow;
      pump_run_q   <= RstPumpRun;
      open_time_q  <= RstValveOpen;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgLevelThreshold: level_thr_q  <= cfg_data_i[LevelW-1:0];
        CfgMinPulses:      min_pulses_q <= cfg_data_i[MinPulW-1:0];
        CfgFlowWindow:     window_len_q <= cfg_data_i[WindowW-1:0];
        CfgPumpRun:        pump_run_q   <= cfg_data_i;
        CfgValveOpen:      open_time_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register in one pass
  // ---------------------------------------------------------------------------
  logic                in_valid_q;
  logic [PulsesW-1:0]  in_pulses_q;
  logic [LevelW-1:0]   in_level_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;

  logic in_fire;
  logic step;     // staged item moves into the result register

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_pulses_q <= s_axis_tdata[PulsesW-1:0];
      in_level_q  <= s_axis_tdata[PulsesW +: LevelW];
    end
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pulse window: sum saturates at full scale, cleared when the window closes
  // ---------------------------------------------------------------------------
  logic [WindowW-1:0]  win_elapsed_q, win_elapsed_d;
  logic [MinPulW-1:0]  win_pulses_q, win_pulses_d;
  logic [MinPulW:0]    pulse_sum_raw;
  logic [MinPulW-1:0]  pulse_sum;
  logic [WindowW:0]    win_count;
  logic [WindowW-1:0]  win_len_eff;
  logic                win_end;
  logic                flow;
  logic                level_ok;

  assign pulse_sum_raw = {1'b0, win_pulses_q} + (MinPulW+1)'(in_pulses_q);
  assign pulse_sum     = pulse_sum_raw[MinPulW] ? PulseMax : pulse_sum_raw[MinPulW-1:0];
  assign win_count     = {1'b0, win_elapsed_q} + 1'b1;
  // a zero window length closes the window every tick
  assign win_len_eff   = (window_len_q == '0) ? WindowW'(1) : window_len_q;
  assign win_end       = win_count >= {1'b0, win_len_eff};
  assign flow          = win_end && (pulse_sum >= min_pulses_q);
  assign level_ok      = in_level_q >= level_thr_q;

  always_comb begin
    if (win_end) begin
      win_elapsed_d = '0;
      win_pulses_d  = '0;
    end else begin
      win_elapsed_d = win_count[WindowW-1:0];
      win_pulses_d  = pulse_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase sequencer with saturating phase timer
  // ---------------------------------------------------------------------------
  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  pump_q, pump_d;
  logic                  valve_q, valve_d;
  logic [DurW-1:0]       dur_sel;
  logic [DurW-1:0]       dur_eff;
  logic                  timer_done;

  // timer sticks at full scale, so an over-long duration never ends
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign dur_sel     = (phase_q == ST_PUMP) ? pump_run_q : open_time_q;
  assign dur_eff     = (dur_sel == '0) ? DurW'(1) : dur_sel;
  assign timer_done  = CmpW'(elapsed_inc) >= CmpW'(dur_eff);

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    pump_d    = pump_q;
    valve_d   = valve_q;
    case (phase_q)
      ST_IDLE: begin
        if (flow) begin
          phase_d   = ST_PUMP;
          elapsed_d = '0;
          pump_d    = 1'b1;
          valve_d   = 1'b1;
        end
      end
      ST_PUMP: begin
        elapsed_d = elapsed_inc;
        if (timer_done) begin
          phase_d   = ST_WAIT;
          elapsed_d = '0;
          pump_d    = 1'b0;
        end
      end
      ST_WAIT: begin
        if (level_ok) begin
          phase_d   = ST_OPEN;
          elapsed_d = '0;
          valve_d   = 1'b0;
        end
      end
      ST_OPEN: begin
        elapsed_d = elapsed_inc;
        if (timer_done) begin
          phase_d   = ST_PUMP;
          elapsed_d = '0;
          pump_d    = 1'b1;
          valve_d   = 1'b1;
        end
      end
      default: phase_d = ST_IDLE;
    endcase
  end

  assign out_data_d = {2'b00, level_ok, flow, phase_d, valve_d, pump_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= ST_IDLE;
      elapsed_q     <= '0;
      pump_q        <= 1'b0;
      valve_q       <= 1'b0;
      win_elapsed_q <= '0;
      win_pulses_q  <= '0;
    end else if (step) begin
      phase_q       <= phase_d;
      elapsed_q     <= elapsed_d;
      pump_q        <= pump_d;
      valve_q       <= valve_d;
      win_elapsed_q <= win_elapsed_d;
      win_pulses_q  <= win_pulses_d;
    end
  end

endmodule

>>> rtl/core/pvfs_checker.sv
// Port-level checks for the fill sequencer, bound to the top level.
module pvfs_checker
  import pvfs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // pump runs exactly in the pumping phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:2] == PhPump)))
    else $error("pump drive disagrees with phase");

  // valve closed while pumping or waiting for level, open otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1] ==
      ((m_axis_tdata[3:2] == PhPump) || (m_axis_tdata[3:2] == PhWait))))
    else $error("valve drive disagrees with phase");

  // input only stalls when a result is waiting and the sink holds off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result item changed");

endmodule

bind pump_valve_fill_sequencer pvfs_checker u_pvfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/pump_valve_fill_sequencer_tb.sv
// Self-checking testbench for the pump and valve fill sequencer.
module pump_valve_fill_sequencer_tb;
  import pvfs_pkg::*;

  localparam int unsigned TimerBits   = 20;
  localparam int unsigned CycleLimit  = 400000;
  // Settle margin after the last result, beyond the block's input and result registers
  localparam int unsigned SettleTicks = 6;
  localparam int unsigned HoldAfter   = 200;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned RandPhases  = 9;
  localparam int unsigned PhaseItems  = 75;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = '1;

  // One result item, laid out exactly as m_axis_tdata (pump_on in bit 0)
  typedef struct packed {
    logic [1:0]        spare;
    logic              level_reached;
    logic              flow_detected;
    logic [PhaseW-1:0] phase;
    logic              valve_closed;
    logic              pump_on;
  } fill_result_t;

  // Predicts the drive outputs tick by tick and checks results in order.
  class fill_scoreboard;
    logic [LevelW-1:0]  level_threshold;
    logic [MinPulW-1:0] min_pulses;
    logic [WindowW-1:0] window_len;
    logic [DurW-1:0]    pump_run;
    logic [DurW-1:0]    open_time;

    logic [PhaseW-1:0]  seq_phase;
    int unsigned        phase_ticks;
    logic [WindowW-1:0] window_ticks;
    logic [MinPulW-1:0] window_sum;
    logic               pump_drive;
    logic               valve_drive;

    fill_result_t       expected_q[$];
    int unsigned        errors;

    function new();
      level_threshold = RstLevelThreshold;
      min_pulses      = RstMinPulses;
      window_len      = RstFlowWindow;
      pump_run        = RstPumpRun;
      open_time       = RstValveOpen;
      seq_phase       = PhIdle;
      phase_ticks     = 0;
      window_ticks    = '0;
      window_sum      = '0;
      pump_drive      = 1'b0;
      valve_drive     = 1'b0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgLevelThreshold: level_threshold = data[LevelW-1:0];
        CfgMinPulses:      min_pulses      = data[MinPulW-1:0];
        CfgFlowWindow:     window_len      = data[WindowW-1:0];
        CfgPumpRun:        pump_run        = data[DurW-1:0];
        CfgValveOpen:      open_time       = data[DurW-1:0];
        default: ;
      endcase
    endfunction

    // Phase timer sticks at its top value rather than wrapping
    function int unsigned timer_step(int unsigned t);
      int unsigned tmax;
      tmax = (32'd1 << TimerBits) - 1;
      return (t >= tmax) ? tmax : t + 1;
    endfunction

    function void note_tick(logic [PulsesW-1:0] pulses, logic [LevelW-1:0] level);
      fill_result_t r;
      int unsigned  sum;
      int unsigned  win;
      int unsigned  next_ticks;
      int unsigned  dur;
      logic         flow;
      logic         lvl_ok;
      lvl_ok = (level >= level_threshold);
      flow   = 1'b0;
      sum    = window_sum + pulses;
      if (sum > PulseMax) sum = PulseMax;
      win        = (window_len == 0) ? 1 : window_len;
      next_ticks = window_ticks + 1;
      // this tick's pulses count before the window end is tested
      if (next_ticks >= win) begin
        flow         = (sum >= min_pulses);
        window_sum   = '0;
        window_ticks = '0;
      end else begin
        window_sum   = sum[MinPulW-1:0];
        window_ticks = next_ticks[WindowW-1:0];
      end
      case (seq_phase)
        PhIdle: if (flow) begin
          pump_drive  = 1'b1;
          valve_drive = 1'b1;
          phase_ticks = 0;
          seq_phase   = PhPump;
        end
        PhPump: begin
          dur         = (pump_run == 0) ? 1 : pump_run;
          phase_ticks = timer_step(phase_ticks);
          if (phase_ticks >= dur) begin
            pump_drive  = 1'b0;
            phase_ticks = 0;
            seq_phase   = PhWait;
          end
        end
        PhWait: if (lvl_ok) begin
          valve_drive = 1'b0;
          phase_ticks = 0;
          seq_phase   = PhOpen;
        end
        default: begin
          dur         = (open_time == 0) ? 1 : open_time;
          phase_ticks = timer_step(phase_ticks);
          if (phase_ticks >= dur) begin
            pump_drive  = 1'b1;
            valve_drive = 1'b1;
            phase_ticks = 0;
            seq_phase   = PhPump;
          end
        end
      endcase
      r.spare         = '0;
      r.level_reached = lvl_ok;
      r.flow_detected = flow;
      r.phase         = seq_phase;
      r.valve_closed  = valve_drive;
      r.pump_on       = pump_drive;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      fill_result_t want;
      fill_result_t got;
      if (expected_q.size() == 0) begin
        $display("%0t: result %h with no tick outstanding, expected none actual %h",
                 $time, data, data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      got  = data;
      check_field("pump_on",       want.pump_on,       got.pump_on);
      check_field("valve_closed",  want.valve_closed,  got.valve_closed);
      check_field("phase",         want.phase,         got.phase);
      check_field("flow_detected", want.flow_detected, got.flow_detected);
      check_field("level_reached", want.level_reached, got.level_reached);
      check_field("padding",       want.spare,         got.spare);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [3:0] tick_pulses, [15:4] level_sample
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [0] pump, [1] valve, [3:2] phase, [4] flow, [5] level
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  fill_scoreboard sb;
  int unsigned    cycles;
  int unsigned    results_seen;
  bit             src_eager;   // sender offers back to back, no gaps
  bit             sink_eager;  // receiver never stalls, bar the long hold

  pump_valve_fill_sequencer #(
    .TIMER_BITS(TimerBits)
  ) DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sampling at the rising edge sees the values driven at the falling edge;
  // register writes, ticks and results are all noted here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_tick(s_axis_tdata[PulsesW-1:0], s_axis_tdata[PulsesW +: LevelW]);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        results_seen++;
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time, sb.pending());
      $display("pump_valve_fill_sequencer_tb failed");
      $finish;
    end
  end

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off once results are flowing,
  // so the block fills and back-pressures the sender.
  initial begin
    int unsigned stall;
    bit          held;
    stall = 0;
    held  = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HoldAfter) begin
        held  = 1'b1;
        stall = HoldCycles;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!sink_eager) stall = pick_gap();
      end
    end
  end

  task automatic send_tick(input logic [PulsesW-1:0] pulses, input logic [LevelW-1:0] level);
    int unsigned gap;
    gap = src_eager ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {level, pulses};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender stops and waits for every outstanding result, then a settle margin
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly small settings so the sequencer cycles through its phases;
  // now and then zero, all ones (masked) or a fully random word.
  function automatic logic [CfgDataW-1:0] pick_setting(logic [CfgIdxW-1:0] idx);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return CfgDataW'($urandom());
    case (idx)
      CfgLevelThreshold: return CfgDataW'($urandom_range(0, 4095));
      CfgMinPulses:      return CfgDataW'($urandom_range(0, 12));
      CfgFlowWindow:     return CfgDataW'($urandom_range(1, 6));
      default:           return CfgDataW'($urandom_range(1, 12));
    endcase
  endfunction

  // Level samples cluster round the threshold and the rails
  function automatic logic [LevelW-1:0] pick_level();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 7);
    if (r < 4) return LevelW'($urandom_range(0, 4095));
    if (r == 6) return '0;
    if (r == 7) return '1;
    v = int'(sb.level_threshold) + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return LevelW'(v);
  endfunction

  initial begin
    logic [PulsesW-1:0] pulses;
    sb            = new();
    cycles        = 0;
    results_seen  = 0;
    src_eager     = 1'b0;
    sink_eager    = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: rails and the level threshold boundary
    send_tick('0, '0);
    send_tick('1, '1);
    send_tick('1, LevelW'(RstLevelThreshold - 1));
    send_tick('0, RstLevelThreshold);
    drain_results();

    // Zero window and zero durations: each phase lasts a single tick,
    // flow found on every tick; a write to an unused index must do nothing.
    write_reg(CfgFlowWindow, '0);
    write_reg(CfgMinPulses, '0);
    write_reg(CfgPumpRun, '0);
    write_reg(CfgValveOpen, '0);
    write_reg(CfgLevelThreshold, '0);
    write_reg(CfgIdxW'(CfgValveOpen + 1), '1);
    repeat (5) send_tick('0, '0);
    drain_results();

    // All-ones writes masked to the widths: threshold at the top of the
    // range, flow unreachable and reported as absent outside idle.
    write_reg(CfgLevelThreshold, '1);
    write_reg(CfgMinPulses, '1);
    send_tick('1, 12'd4094);
    send_tick('1, '1);
    send_tick('0, '1);
    send_tick(4'd7, 12'd2048);
    send_tick('1, '1);
    drain_results();

    for (int ph = 0; ph < RandPhases; ph++) begin
      for (int idx = CfgLevelThreshold; idx <= CfgValveOpen; idx++)
        write_reg(CfgIdxW'(idx), pick_setting(CfgIdxW'(idx)));
      write_reg(CfgIdxW'($urandom_range(CfgValveOpen + 1, CfgIdxTop)),
                CfgDataW'($urandom()));
      // Long window and a high minimum: the pulse sum has to saturate
      if (ph == 2) begin
        write_reg(CfgFlowWindow, CfgDataW'(90));
        write_reg(CfgMinPulses, CfgDataW'(1000));
      end
      src_eager  = (ph % 3 == 1);
      sink_eager = (ph % 4 == 2);
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 4 && i == PhaseItems / 2) drain_results();
        if (ph == 2 && $urandom_range(0, 4) != 0) pulses = '1;
        else if ($urandom_range(0, 5) == 0) pulses = '0;
        else pulses = PulsesW'($urandom_range(0, 15));
        send_tick(pulses, pick_level());
      end
      drain_results();
    end

    if (sb.errors == 0) begin
      $display("pump_valve_fill_sequencer_tb passed");
    end else begin
      $display("pump_valve_fill_sequencer_tb failed");
    end
    $finish;
  end

endmodule
